>>> rtl/core/ultrasonic_ranging_presence_macros.svh
// assertion macros for the ultrasonic ranging presence block
`ifndef ULTRASONIC_RANGING_PRESENCE_MACROS_SVH
`define ULTRASONIC_RANGING_PRESENCE_MACROS_SVH

// same-cycle implication, checked out of reset
`define URP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define URP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/urp_pkg.sv
// shared types and constants for the ultrasonic ranging presence block
`default_nettype none
package urp_pkg;

  localparam int unsigned MAX_RANGE_US = 23200;
  localparam int unsigned US_PER_CM    = 58;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRIGGER   = 2'd3;

  localparam logic [8:0]  RST_THRESHOLD = 9'd50;
  localparam logic [19:0] RST_INTERVAL  = 20'd100000;
  localparam logic [15:0] RST_TIMEOUT   = 16'd30000;
  localparam logic [7:0]  RST_TRIGGER   = 8'd10;

  localparam logic [19:0] IDLE_MAX = 20'hFFFFF;
  localparam logic [15:0] W16_MAX  = 16'hFFFF;
  localparam logic [8:0]  TLOW_TICKS = 9'd2;

  typedef enum logic [2:0] {
    OC_NONE       = 3'd0,
    OC_IN_RANGE   = 3'd1,
    OC_OUT_RANGE  = 3'd2,
    OC_TIMEOUT    = 3'd3,
    OC_ZERO_WIDTH = 3'd4
  } outcome_t;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_TLOW  = 4'b0010,
    MODE_THIGH = 4'b0100,
    MODE_WAIT  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [8:0]  near_cm;
    logic [19:0] interval_us;
    logic [15:0] timeout_us;
    logic [7:0]  trigger_us;
  } cfg_t;

  typedef struct packed {
    logic        trigger_level;
    logic        measure_done;
    outcome_t    outcome;
    logic [15:0] pulse_width_us;
    logic        present;
    logic        presence_report;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/core/urp_cfg_regs.sv
// configuration register file
`default_nettype none
module urp_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [urp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [urp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output urp_pkg::cfg_t                       cfg
);
  import urp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_THRESHOLD: cfg_nxt.near_cm     = cfg_wdata[8:0];
        CFG_INTERVAL:  cfg_nxt.interval_us = cfg_wdata[19:0];
        CFG_TIMEOUT:   cfg_nxt.timeout_us  = cfg_wdata[15:0];
        CFG_TRIGGER:   cfg_nxt.trigger_us  = cfg_wdata[7:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_cm     <= RST_THRESHOLD;
      cfg_r.interval_us <= RST_INTERVAL;
      cfg_r.timeout_us  <= RST_TIMEOUT;
      cfg_r.trigger_us  <= RST_TRIGGER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> rtl/core/urp_seq_core.sv
// ranging sequencer state and per-tick result logic
`default_nettype none
`include "ultrasonic_ranging_presence_macros.svh"
module urp_seq_core (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step_en,
  input  wire logic      echo_level,
  input  wire logic      enable,
  input  wire urp_pkg::cfg_t cfg,
  output urp_pkg::result_t res
);
  import urp_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [19:0] idle_count_r, idle_count_nxt;
  logic [7:0]  trigger_phase_r, trigger_phase_nxt;
  logic [15:0] wait_count_r, wait_count_nxt;
  logic [15:0] width_count_r, width_count_nxt;
  logic        rise_seen_r, rise_seen_nxt;
  logic        echo_prev_r, echo_prev_nxt;
  logic        present_flag_r, present_flag_nxt;

  logic [8:0]  phase_inc;
  logic [15:0] thresh_us;
  logic        rise;
  logic        fall;
  logic        done;
  result_t     res_c;

  assign phase_inc = {1'b0, trigger_phase_r} + 9'd1;
  assign thresh_us = 16'(cfg.near_cm) * 16'(US_PER_CM);
  assign rise      = echo_level && !echo_prev_r;
  assign fall      = !echo_level && echo_prev_r;

  always_comb begin
    mode_nxt          = mode_r;
    idle_count_nxt    = idle_count_r;
    trigger_phase_nxt = trigger_phase_r;
    wait_count_nxt    = wait_count_r;
    width_count_nxt   = width_count_r;
    rise_seen_nxt     = rise_seen_r;
    present_flag_nxt  = present_flag_r;
    echo_prev_nxt     = echo_level;
    done              = 1'b0;
    res_c             = '0;
    res_c.outcome     = OC_NONE;

    if (!enable) begin
      mode_nxt          = MODE_IDLE;
      trigger_phase_nxt = '0;
      wait_count_nxt    = '0;
      width_count_nxt   = '0;
      rise_seen_nxt     = 1'b0;
      if (idle_count_r != IDLE_MAX) idle_count_nxt = idle_count_r + 20'd1;
    end else begin
      unique case (mode_r)
        MODE_IDLE: begin
          if (idle_count_r >= cfg.interval_us) begin
            mode_nxt          = MODE_TLOW;
            trigger_phase_nxt = 8'd1;
          end else begin
            idle_count_nxt = idle_count_r + 20'd1;
          end
        end
        MODE_TLOW: begin
          trigger_phase_nxt = phase_inc[7:0];
          if (phase_inc >= TLOW_TICKS) begin
            trigger_phase_nxt = '0;
            if (cfg.trigger_us == '0) begin
              mode_nxt        = MODE_WAIT;
              wait_count_nxt  = '0;
              width_count_nxt = '0;
              rise_seen_nxt   = 1'b0;
            end else begin
              mode_nxt = MODE_THIGH;
            end
          end
        end
        MODE_THIGH: begin
          res_c.trigger_level = 1'b1;
          trigger_phase_nxt   = phase_inc[7:0];
          if (phase_inc >= {1'b0, cfg.trigger_us}) begin
            trigger_phase_nxt = '0;
            mode_nxt          = MODE_WAIT;
            wait_count_nxt    = '0;
            width_count_nxt   = '0;
            rise_seen_nxt     = 1'b0;
          end
        end
        MODE_WAIT: begin
          if (rise) begin
            rise_seen_nxt   = 1'b1;
            width_count_nxt = 16'd1;
          end else if (fall) begin
            done = 1'b1;
            if (!rise_seen_r) begin
              res_c.outcome = OC_OUT_RANGE;
            end else begin
              res_c.pulse_width_us = width_count_r;
              if (width_count_r == '0) begin
                res_c.outcome = OC_ZERO_WIDTH;
              end else if (width_count_r > 16'(MAX_RANGE_US)) begin
                res_c.outcome = OC_OUT_RANGE;
              end else begin
                res_c.outcome = OC_IN_RANGE;
                if (width_count_r <= thresh_us) begin
                  present_flag_nxt      = 1'b1;
                  res_c.presence_report = 1'b1;
                end
              end
            end
          end else if (rise_seen_r && echo_level) begin
            if (width_count_r != W16_MAX) width_count_nxt = width_count_r + 16'd1;
          end
          if (!done) begin
            if (wait_count_r >= cfg.timeout_us) begin
              done                 = 1'b1;
              res_c.outcome        = OC_TIMEOUT;
              res_c.pulse_width_us = '0;
            end else begin
              wait_count_nxt = wait_count_r + 16'd1;
            end
          end
          if (done) begin
            mode_nxt        = MODE_IDLE;
            idle_count_nxt  = '0;
            wait_count_nxt  = '0;
            width_count_nxt = '0;
            rise_seen_nxt   = 1'b0;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
    end
    res_c.measure_done = done;
    res_c.present      = present_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_IDLE;
      idle_count_r    <= '0;
      trigger_phase_r <= '0;
      wait_count_r    <= '0;
      width_count_r   <= '0;
      rise_seen_r     <= 1'b0;
      echo_prev_r     <= 1'b0;
      present_flag_r  <= 1'b0;
    end else if (step_en) begin
      mode_r          <= mode_nxt;
      idle_count_r    <= idle_count_nxt;
      trigger_phase_r <= trigger_phase_nxt;
      wait_count_r    <= wait_count_nxt;
      width_count_r   <= width_count_nxt;
      rise_seen_r     <= rise_seen_nxt;
      echo_prev_r     <= echo_prev_nxt;
      present_flag_r  <= present_flag_nxt;
    end
  end

  assign res = res_c;

  `URP_ASSERT_IMP(a_report_in_range, res_c.presence_report,
                  res_c.measure_done && (res_c.outcome == OC_IN_RANGE),
                  "presence report without in-range conclusion")
  `URP_ASSERT_NEXT(a_done_to_idle, step_en && res_c.measure_done,
                   (mode_r == MODE_IDLE) && (idle_count_r == '0),
                   "measurement concluded but sequencer not back in idle")
  `URP_ASSERT_NEXT(a_present_sticky, present_flag_r, present_flag_r,
                   "present flag cleared outside reset")

endmodule
`default_nettype wire

>>> rtl/core/ultrasonic_ranging_presence.sv
// a result is registered into the output register, or into the skid register while the output stalls
// throughput: one tick per cycle while in_ready is high; in_ready drops while the skid entry holds a result
// a two-entry output buffer keeps input ready high while one result waits
// reset (synchronous, active low) restores register defaults and clears state
// the present flag clears only at reset
`default_nettype none
module ultrasonic_ranging_presence (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_echo_level,
  input  wire logic                           in_enable,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_trigger_level,
  output logic                                out_measure_done,
  output logic [2:0]                          out_outcome,
  output logic [15:0]                         out_pulse_width_us,
  output logic                                out_present,
  output logic                                out_presence_report,
  input  wire logic                           cfg_we,
  input  wire logic [urp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [urp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import urp_pkg::*;

  cfg_t    cfg;
  result_t step_res;
  logic    in_accept;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;

  assign in_ready  = !skid_valid_r;
  assign in_accept = in_valid && in_ready;

  urp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  urp_seq_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_accept),
    .echo_level (in_echo_level),
    .enable     (in_enable),
    .cfg        (cfg),
    .res        (step_res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && !out_ready) begin
      if (in_accept) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = step_res;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = in_accept;
      out_data_nxt  = step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_trigger_level   = out_data_r.trigger_level;
  assign out_measure_done    = out_data_r.measure_done;
  assign out_outcome         = out_data_r.outcome;
  assign out_pulse_width_us  = out_data_r.pulse_width_us;
  assign out_present         = out_data_r.present;
  assign out_presence_report = out_data_r.presence_report;

endmodule
`default_nettype wire
